@@ hw/rtl/fps_ovl_pkg.sv @@
package fps_ovl_pkg;

    localparam int NUM_STAGES = 4;

    localparam int COORD_W = 12;
    localparam int COLOR_W = 16;
    localparam int RATE_W  = 16;
    localparam int CFG_W   = 12;

    localparam logic [0:0] REG_OVERLAY_ENABLE = 1'd0;
    localparam logic [0:0] REG_SCREEN_WIDTH   = 1'd1;

    localparam logic [CFG_W-1:0] SCREEN_WIDTH_RESET = 12'd320;

    localparam int BOX_W = 60;
    localparam int BOX_H = 16;
    localparam logic [COLOR_W-1:0] WHITE_565 = 16'hffff;
    localparam logic [COLOR_W-1:0] BLACK_565 = 16'h0000;

    // x / 10 == (x * 52429) >> 19 for every 16-bit x
    localparam logic [15:0] RECIP_10 = 16'd52429;
    localparam int RECIP_10_SHIFT = 19;

    // x / 7 == (x * 37) >> 8 for x below 84
    localparam logic [11:0] RECIP_7 = 12'd37;

    localparam logic [3:0] GLYPH_F     = 4'd10;
    localparam logic [3:0] GLYPH_P     = 4'd11;
    localparam logic [3:0] GLYPH_S     = 4'd12;
    localparam logic [3:0] GLYPH_BLANK = 4'd13;

    localparam logic [2:0] SLOT_F      = 3'd0;
    localparam logic [2:0] SLOT_P      = 3'd1;
    localparam logic [2:0] SLOT_S      = 3'd2;
    localparam logic [2:0] SLOT_TENS   = 3'd3;
    localparam logic [2:0] SLOT_UNITS  = 3'd4;
    localparam logic [2:0] SLOT_POINT  = 3'd5;
    localparam logic [2:0] SLOT_TENTHS = 3'd6;

    localparam logic [2:0] GLYPH_ROM [0:13][0:4] = '{
        '{3'd7, 3'd5, 3'd5, 3'd5, 3'd7},
        '{3'd2, 3'd6, 3'd2, 3'd2, 3'd7},
        '{3'd7, 3'd1, 3'd7, 3'd4, 3'd7},
        '{3'd7, 3'd1, 3'd7, 3'd1, 3'd7},
        '{3'd5, 3'd5, 3'd7, 3'd1, 3'd1},
        '{3'd7, 3'd4, 3'd7, 3'd1, 3'd7},
        '{3'd7, 3'd4, 3'd7, 3'd5, 3'd7},
        '{3'd7, 3'd1, 3'd2, 3'd2, 3'd2},
        '{3'd7, 3'd5, 3'd7, 3'd5, 3'd7},
        '{3'd7, 3'd5, 3'd7, 3'd1, 3'd7},
        '{3'd7, 3'd4, 3'd6, 3'd4, 3'd4},
        '{3'd6, 3'd5, 3'd6, 3'd4, 3'd4},
        '{3'd7, 3'd4, 3'd7, 3'd1, 3'd7},
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
    };

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctrl_t;

    typedef struct packed {
        logic                in_box;
        logic                text_ok;
        logic [2:0]          slot;
        logic [1:0]          gx;
        logic [2:0]          row;
        logic [COLOR_W-1:0]  color;
    } geom_t;

    typedef struct packed {
        logic [3:0] tenths;
        logic [3:0] units;
        logic [3:0] tens;
    } digits_t;

    function automatic logic [2:0] glyph_line(input logic [3:0] idx, input logic [2:0] row);
        logic [2:0] bits;
        bits = 3'd0;
        if (idx <= GLYPH_BLANK && row <= 3'd4) begin
            bits = GLYPH_ROM[idx][row];
        end
        return bits;
    endfunction

    // low four bits of 10 * x
    function automatic logic [3:0] mul10_lo(input logic [3:0] x);
        logic [7:0] prod;
        prod = {1'b0, x, 3'b000} + {3'b000, x, 1'b0};
        return prod[3:0];
    endfunction

endpackage

@@ hw/rtl/fps_ovl_ctrl.sv @@
module fps_ovl_ctrl
    import fps_ovl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pipe_ctrl_t            ctrl,
    output logic [NUM_STAGES-1:0] stage_valid
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] ready;

    // a stage may load when it is empty or its contents move on
    always_comb begin
        ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
    end

    always_comb begin
        valid_next[0] = ready[0] ? s_valid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            valid_next[i] = ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.load   = ready;
    assign s_ready     = ready[0];
    assign m_valid     = valid_reg[NUM_STAGES-1];
    assign stage_valid = valid_reg;

endmodule

@@ hw/rtl/fps_ovl_digits.sv @@
module fps_ovl_digits
    import fps_ovl_pkg::*;
(
    input  logic              aclk,
    input  pipe_ctrl_t        ctrl,
    input  logic [RATE_W-1:0] rate_tenths,
    output digits_t           digits
);

    logic [31:0] prod_a;
    logic [28:0] prod_b;
    logic [25:0] prod_c;

    logic [12:0] a_q1_reg;
    logic [3:0]  a_rate_lo_reg;

    logic [9:0]  b_q2_reg;
    logic [3:0]  b_q1_lo_reg;
    logic [3:0]  b_tenths_reg;

    logic [6:0]  c_q3_reg;
    logic [3:0]  c_q2_lo_reg;
    logic [3:0]  c_units_reg;
    logic [3:0]  c_tenths_reg;

    // peel one decimal digit per stage
    assign prod_a = {16'd0, rate_tenths} * {16'd0, RECIP_10};
    assign prod_b = {16'd0, a_q1_reg} * {13'd0, RECIP_10};
    assign prod_c = {16'd0, b_q2_reg} * {10'd0, RECIP_10};

    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            a_q1_reg      <= prod_a[31:RECIP_10_SHIFT];
            a_rate_lo_reg <= rate_tenths[3:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[1]) begin
            b_q2_reg     <= prod_b[28:RECIP_10_SHIFT];
            b_q1_lo_reg  <= a_q1_reg[3:0];
            b_tenths_reg <= a_rate_lo_reg - mul10_lo(a_q1_reg[3:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[2]) begin
            c_q3_reg     <= prod_c[25:RECIP_10_SHIFT];
            c_q2_lo_reg  <= b_q2_reg[3:0];
            c_units_reg  <= b_q1_lo_reg - mul10_lo(b_q2_reg[3:0]);
            c_tenths_reg <= b_tenths_reg;
        end
    end

    assign digits.tenths = c_tenths_reg;
    assign digits.units  = c_units_reg;
    assign digits.tens   = c_q2_lo_reg - mul10_lo(c_q3_reg[3:0]);

endmodule

@@ hw/rtl/fps_ovl_geom.sv @@
module fps_ovl_geom
    import fps_ovl_pkg::*;
(
    input  logic               aclk,
    input  pipe_ctrl_t         ctrl,
    input  logic               cfg_enable,
    input  logic [CFG_W-1:0]   cfg_width,
    input  logic [COORD_W-1:0] pos_x,
    input  logic [COORD_W-1:0] pos_y,
    input  logic [COLOR_W-1:0] color_in,
    output geom_t              geom
);

    logic signed [13:0] diff;
    logic signed [13:0] left;
    logic signed [13:0] dx;
    logic               in_box;
    logic               rx_ok;
    logic               row_ok;
    logic [5:0]         rx;
    logic [3:0]         ry;

    logic               a_in_box_reg;
    logic               a_rx_ok_reg;
    logic               a_row_ok_reg;
    logic [5:0]         a_rx_reg;
    logic [2:0]         a_row_reg;
    logic [COLOR_W-1:0] a_color_reg;

    logic [11:0]        slot_prod;
    logic               b_in_box_reg;
    logic               b_rx_ok_reg;
    logic               b_row_ok_reg;
    logic [5:0]         b_rx_reg;
    logic [3:0]         b_slot_reg;
    logic [2:0]         b_row_reg;
    logic [COLOR_W-1:0] b_color_reg;

    logic [6:0]         seven_slot;
    logic [6:0]         col_full;
    logic [2:0]         col;
    geom_t              c_geom_reg;

    // left edge, halved with truncation toward zero
    always_comb begin
        diff   = $signed({2'b00, cfg_width}) - 14'sd60;
        left   = (diff + $signed({13'd0, diff[13]})) >>> 1;
        dx     = $signed({2'b00, pos_x}) - left;
        in_box = cfg_enable && !dx[13] && (dx < 14'sd60) && (pos_y < 12'd16);
        rx_ok  = (dx >= 14'sd3);
        rx     = dx[5:0] - 6'd3;
        row_ok = pos_y inside {[12'd3:12'd12]};
        ry     = pos_y[3:0] - 4'd3;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            a_in_box_reg <= in_box;
            a_rx_ok_reg  <= rx_ok;
            a_row_ok_reg <= row_ok;
            a_rx_reg     <= rx;
            a_row_reg    <= ry[3:1];
            a_color_reg  <= color_in;
        end
    end

    assign slot_prod = {6'd0, a_rx_reg} * RECIP_7;

    always_ff @(posedge aclk) begin
        if (ctrl.load[1]) begin
            b_in_box_reg <= a_in_box_reg;
            b_rx_ok_reg  <= a_rx_ok_reg;
            b_row_ok_reg <= a_row_ok_reg;
            b_rx_reg     <= a_rx_reg;
            b_slot_reg   <= slot_prod[11:8];
            b_row_reg    <= a_row_reg;
            b_color_reg  <= a_color_reg;
        end
    end

    // column within the 7-pixel character cell
    always_comb begin
        seven_slot = {b_slot_reg, 3'b000} - {3'b000, b_slot_reg};
        col_full   = {1'b0, b_rx_reg} - seven_slot;
        col        = col_full[2:0];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[2]) begin
            c_geom_reg.in_box  <= b_in_box_reg;
            c_geom_reg.text_ok <= b_rx_ok_reg && b_row_ok_reg
                                  && (b_slot_reg < 4'd7) && (col < 3'd6);
            c_geom_reg.slot    <= b_slot_reg[2:0];
            c_geom_reg.gx      <= col[2:1];
            c_geom_reg.row     <= b_row_reg;
            c_geom_reg.color   <= b_color_reg;
        end
    end

    assign geom = c_geom_reg;

endmodule

@@ hw/rtl/fps_text_pixel_overlay.sv @@
// Frame-rate text overlay on an RGB565 pixel stream.
// Throughput: one pixel per cycle while m_ready is high; four register stages
// under a ready chain, so a stall on m_ready holds each full stage in place
// while empty ones fill.
// Reset (aresetn low, synchronous): pipeline emptied, overlay disabled,
// screen width 320.
module fps_text_pixel_overlay
    import fps_ovl_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [0:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [COORD_W-1:0] s_pos_x,
    input  logic [COORD_W-1:0] s_pos_y,
    input  logic [COLOR_W-1:0] s_color_in,
    input  logic [RATE_W-1:0]  s_rate_tenths,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COLOR_W-1:0] m_color_out,
    output logic               m_drawn
);

    logic                  overlay_enable_reg;
    logic [CFG_W-1:0]      screen_width_reg;

    pipe_ctrl_t            ctrl;
    logic [NUM_STAGES-1:0] stage_valid;
    geom_t                 geom;
    digits_t               digits;

    logic [3:0]            glyph_idx;
    logic [2:0]            row_bits;
    logic                  lit;
    logic [COLOR_W-1:0]    color_next;

    logic [COLOR_W-1:0]    color_out_reg;
    logic                  drawn_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            overlay_enable_reg <= 1'b0;
            screen_width_reg   <= SCREEN_WIDTH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_OVERLAY_ENABLE: overlay_enable_reg <= cfg_wdata[0];
                REG_SCREEN_WIDTH:   screen_width_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    fps_ovl_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .ctrl        (ctrl),
        .stage_valid (stage_valid)
    );

    fps_ovl_geom u_geom (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .cfg_enable (overlay_enable_reg),
        .cfg_width  (screen_width_reg),
        .pos_x      (s_pos_x),
        .pos_y      (s_pos_y),
        .color_in   (s_color_in),
        .geom       (geom)
    );

    fps_ovl_digits u_digits (
        .aclk        (aclk),
        .ctrl        (ctrl),
        .rate_tenths (s_rate_tenths),
        .digits      (digits)
    );

    always_comb begin
        case (geom.slot)
            SLOT_F:      glyph_idx = GLYPH_F;
            SLOT_P:      glyph_idx = GLYPH_P;
            SLOT_S:      glyph_idx = GLYPH_S;
            SLOT_TENS:   glyph_idx = digits.tens;
            SLOT_UNITS:  glyph_idx = digits.units;
            SLOT_TENTHS: glyph_idx = digits.tenths;
            default:     glyph_idx = GLYPH_BLANK;
        endcase
        row_bits = glyph_line(glyph_idx, geom.row);
        lit      = geom.text_ok && row_bits[2'd2 - geom.gx];
        if (!geom.in_box) begin
            color_next = geom.color;
        end else if (lit) begin
            color_next = WHITE_565;
        end else begin
            color_next = BLACK_565;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[NUM_STAGES-1]) begin
            color_out_reg <= color_next;
            drawn_reg     <= geom.in_box;
        end
    end

    assign m_color_out = color_out_reg;
    assign m_drawn     = drawn_reg;

    a_drawn_colour: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_drawn |-> (m_color_out == BLACK_565) || (m_color_out == WHITE_565))
        else $error("drawn pixel is neither black nor white");

    a_disabled_passes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !overlay_enable_reg |-> !m_drawn)
        else $error("pixel drawn with the overlay disabled");

    a_backpressure_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&stage_valid) && !m_ready)
        else $error("input stalled while the pipeline has room");

    a_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && (stage_valid == '0))
        else $error("pipeline not empty after reset");

endmodule

@@ tb/fps_text_pixel_overlay_test.sv @@
module fps_text_pixel_overlay_test;
    import fps_ovl_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_OFF_LEN  = 300;
    localparam int MAX_REPORTS   = 100;
    localparam int NUM_SETTINGS  = 10;
    localparam int PIXELS_PER_SETTING = 200;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               drawn;
    } overlay_px_t;

    class overlay_scoreboard;
        bit             enable;
        bit [CFG_W-1:0] width;
        overlay_px_t    pending_px[$];
        int             errors;

        function new();
            enable = 1'b0;
            width  = SCREEN_WIDTH_RESET;
            errors = 0;
        endfunction

        function int pending();
            return pending_px.size();
        endfunction

        // rows of a 3x5 glyph, top row in the upper bits
        function logic [14:0] font_rows(logic [3:0] g);
            case (g)
                4'd0:    return 15'b111_101_101_101_111;
                4'd1:    return 15'b010_110_010_010_111;
                4'd2:    return 15'b111_001_111_100_111;
                4'd3:    return 15'b111_001_111_001_111;
                4'd4:    return 15'b101_101_111_001_001;
                4'd5:    return 15'b111_100_111_001_111;
                4'd6:    return 15'b111_100_111_101_111;
                4'd7:    return 15'b111_001_010_010_010;
                4'd8:    return 15'b111_101_111_101_111;
                4'd9:    return 15'b111_101_111_001_111;
                GLYPH_F: return 15'b111_100_110_100_100;
                GLYPH_P: return 15'b110_101_110_100_100;
                GLYPH_S: return 15'b111_100_111_001_111;
                default: return 15'b000_000_000_000_000;
            endcase
        endfunction

        function logic [3:0] glyph_of(logic [2:0] slot, logic [RATE_W-1:0] rate);
            case (slot)
                SLOT_F:      return GLYPH_F;
                SLOT_P:      return GLYPH_P;
                SLOT_S:      return GLYPH_S;
                SLOT_TENS:   return 4'((rate / 100) % 10);
                SLOT_UNITS:  return 4'((rate / 10) % 10);
                SLOT_TENTHS: return 4'(rate % 10);
                default:     return GLYPH_BLANK;
            endcase
        endfunction

        function overlay_px_t shade_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                          logic [COLOR_W-1:0] color,
                                          logic [RATE_W-1:0] rate);
            overlay_px_t px;
            int          left, dx, rx, ry, slot, col;
            logic [14:0] rows;
            logic [2:0]  bits;
            px.color = color;
            px.drawn = 1'b0;
            left = (int'(width) - BOX_W) / 2;
            dx   = int'(x) - left;
            if (!enable || dx < 0 || dx >= BOX_W || int'(y) >= BOX_H) begin
                return px;
            end
            px.color = BLACK_565;
            px.drawn = 1'b1;
            rx = dx - 3;
            ry = int'(y) - 3;
            if (rx >= 0 && ry >= 0 && ry < 10) begin
                slot = rx / 7;
                col  = rx % 7;
                // the seventh column of each cell is the gap between characters
                if (slot < 7 && col < 6) begin
                    rows = font_rows(glyph_of(3'(slot), rate));
                    bits = rows[14 - 3 * (ry / 2) -: 3];
                    if (bits[2 - col / 2]) begin
                        px.color = WHITE_565;
                    end
                end
            end
            return px;
        endfunction

        function void note_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                 logic [COLOR_W-1:0] color, logic [RATE_W-1:0] rate);
            pending_px.push_back(shade_pixel(x, y, color, rate));
        endfunction

        function void check_pixel(logic [COLOR_W-1:0] color, logic drawn);
            overlay_px_t want;
            if (pending_px.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: result with no pixel pending, color_out %h drawn %b",
                             $time, color, drawn);
                end
                return;
            end
            want = pending_px.pop_front();
            if (color !== want.color) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: color_out expected %h, actual %h",
                             $time, want.color, color);
                end
            end
            if (drawn !== want.drawn) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: drawn expected %b, actual %b", $time, want.drawn, drawn);
                end
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [0:0]         cfg_index = REG_OVERLAY_ENABLE;
    logic [CFG_W-1:0]   cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [COORD_W-1:0] s_pos_x = '0;
    logic [COORD_W-1:0] s_pos_y = '0;
    logic [COLOR_W-1:0] s_color_in = '0;
    logic [RATE_W-1:0]  s_rate_tenths = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [COLOR_W-1:0] m_color_out;
    logic               m_drawn;

    overlay_scoreboard sb;
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    int  quiet_cycles = 0;

    fps_text_pixel_overlay u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_color_in    (s_color_in),
        .s_rate_tenths (s_rate_tenths),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_color_out   (m_color_out),
        .m_drawn       (m_drawn)
    );

    always #6 aclk = ~aclk;

    // receiver: random stalls, or a long hold-off on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_OFF_LEN;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // record both channels and watch for a stuck pipeline
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_pixel(s_pos_x, s_pos_y, s_color_in, s_rate_tenths);
            end
            if (m_valid && m_ready) begin
                sb.check_pixel(m_color_out, m_drawn);
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("fps_text_pixel_overlay_test: done, errors");
            $finish;
        end
    end

    task automatic send_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic [COLOR_W-1:0] color, logic [RATE_W-1:0] rate);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pos_x       <= x;
        s_pos_y       <= y;
        s_color_in    <= color;
        s_rate_tenths <= rate;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_random_pixel();
        int                 left, lo, hi;
        logic [COORD_W-1:0] x, y;
        logic [COLOR_W-1:0] color;
        logic [RATE_W-1:0]  rate;
        left  = (int'(sb.width) - BOX_W) / 2;
        color = COLOR_W'($urandom);
        rate  = RATE_W'(($urandom_range(3) == 0) ? $urandom_range(999) : $urandom);
        // mostly aim at the box and its rim
        if ($urandom_range(9) < 7) begin
            lo = (left - 4 < 0) ? 0 : left - 4;
            hi = (left + BOX_W + 3 > 4095) ? 4095 : left + BOX_W + 3;
            x  = COORD_W'($urandom_range(hi, lo));
            y  = COORD_W'($urandom_range(BOX_H + 3));
        end else begin
            x = COORD_W'($urandom);
            y = COORD_W'($urandom);
        end
        send_pixel(x, y, color, rate);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic apply_setting(bit en, logic [CFG_W-1:0] width);
        wait_drained();
        repeat (NUM_STAGES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_OVERLAY_ENABLE;
        cfg_wdata <= CFG_W'(en);
        @(posedge aclk);
        cfg_index <= REG_SCREEN_WIDTH;
        cfg_wdata <= width;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.enable = en;
        sb.width  = width;
    endtask

    initial begin
        bit               en_list[NUM_SETTINGS];
        logic [CFG_W-1:0] width_list[NUM_SETTINGS];
        sb = new();
        en_list    = '{1, 1, 1, 1, 1, 1, 0, 1, 1, 1};
        width_list = '{320, 0, 4095, 59, 58, 60, 61, 12'd0, 1, 640};
        width_list[7] = CFG_W'($urandom_range(4095));
        tx_idle_pct = 16;
        rx_idle_pct = 52;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // out of reset the overlay is off
        send_pixel(133, 3, 16'habcd, 1234);
        send_pixel(130, 0, 16'h5a5a, 0);

        apply_setting(1'b1, 320);
        send_pixel(130, 0, 16'h1234, 1234);      // box corners and just outside
        send_pixel(189, 15, 16'h1234, 1234);
        send_pixel(129, 0, 16'h1234, 1234);
        send_pixel(190, 0, 16'h1234, 1234);
        send_pixel(130, 16, 16'h1234, 1234);
        send_pixel(133, 3, 16'h0000, 1234);      // top left of F
        send_pixel(139, 3, 16'h0000, 1234);      // gap between characters
        send_pixel(168, 5, 16'hffff, 1234);      // decimal point stays black
        send_pixel(133, 12, 16'h0000, 1234);     // last glyph row
        send_pixel(133, 13, 16'h0000, 1234);     // below the text
        send_pixel(132, 3, 16'h0000, 1234);      // margin left of the text
        send_pixel(154, 3, 16'h0000, 16'hffff);  // large rate, lowest digits only
        send_pixel(175, 9, 16'h0000, 0);
        send_pixel(177, 9, 16'h0000, 0);
        send_pixel(161, 5, 16'h0000, 999);
        send_pixel(182, 5, 16'h0000, 999);       // right margin of the box
        send_pixel(4095, 4095, 16'hffff, 16'hffff);
        send_pixel(0, 0, 16'h0000, 0);

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            if (s == 4) begin
                tx_idle_pct = 52;
                rx_idle_pct = 16;
            end else if (s == 7) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            apply_setting(en_list[s], width_list[s]);
            for (int i = 0; i < PIXELS_PER_SETTING; i++) begin
                if (s == 2 && i == PIXELS_PER_SETTING / 2) begin
                    hold_req = 1'b1;
                end
                if (s == 5 && i == PIXELS_PER_SETTING / 2) begin
                    wait_drained();
                end
                send_random_pixel();
            end
        end

        wait_drained();
        repeat (NUM_STAGES + 4) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("fps_text_pixel_overlay_test: done, clean");
        end else begin
            $display("fps_text_pixel_overlay_test: done, errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/fps_ovl_pkg.sv
hw/rtl/fps_ovl_ctrl.sv
hw/rtl/fps_ovl_digits.sv
hw/rtl/fps_ovl_geom.sv
hw/rtl/fps_text_pixel_overlay.sv
tb/fps_text_pixel_overlay_test.sv
